>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file, which carries the checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising edge of clock, with reset excluded.
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the cycle after.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/dwg_pkg.sv
// Package for the damped wave grid: widths, opcodes, reset coefficients,
// controller-to-datapath command types and the saturating helper. No dependencies.
`default_nettype none
package dwg_pkg;
   localparam int DEFAULT_COLS = 64;
   localparam int DEFAULT_ROWS = 64;
   localparam int IDX_W = 12;
   localparam int VAL_W = 32;
   localparam int COEF_W = 20;
   localparam int OP_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [OP_W-1:0] OP_STEP = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SELF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NBR = 2'd2;

   localparam logic signed [COEF_W-1:0] COEF_SELF_RST = 20'sd127119;
   localparam logic signed [COEF_W-1:0] COEF_PREV_RST = -20'sd64884;
   localparam logic signed [COEF_W-1:0] COEF_NBR_RST = 20'sd825;

   // Controller commands, one per cycle.
   typedef struct packed {
      logic                clr;       // write zeros at addr in all three banks
      logic                cell_rd;   // clear the result register (step)
      logic                cell_wr;   // write add result to now[addr]
      logic                sweep;     // a step sweep is active
      logic                load;      // feed window (read ahead)
      logic                wb;        // write back delayed result
      logic [IDX_W-1:0]    addr;
      logic [IDX_W-1:0]    wb_addr;
      logic [8:0]          wb_row;    // for boundary muxing, row/col of the cell at stage
      logic [8:0]          wb_col;
      logic                wb_hold;   // capture now[addr] as the read result
      logic                bank_flip;
   } dwg_cmd_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W+1:0] v);
      logic signed [VAL_W+1:0] hi, lo;
      hi = {3'b000, {(VAL_W-1){1'b1}}};
      lo = {3'b111, {(VAL_W-1){1'b0}}};
      if (v > hi) sat32 = {1'b0, {(VAL_W-1){1'b1}}};
      else if (v < lo) sat32 = {1'b1, {(VAL_W-1){1'b0}}};
      else sat32 = v[VAL_W-1:0];
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/dwg_datapath.sv
// Datapath of the damped wave grid: three grid memory banks, the stencil pipeline
// and the add/read path. Depends on dwg_pkg.
`default_nettype none
module dwg_datapath #(
   parameter int COLS = dwg_pkg::DEFAULT_COLS,
   parameter int ROWS = dwg_pkg::DEFAULT_ROWS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire dwg_pkg::dwg_cmd_type                 cmd,
   input  wire logic [dwg_pkg::IDX_W-1:0]            cell_index,
   input  wire logic signed [dwg_pkg::VAL_W-1:0]     delta,
   input  wire logic                                 index_ok,
   input  wire logic signed [dwg_pkg::COEF_W-1:0]    coef_self,
   input  wire logic signed [dwg_pkg::COEF_W-1:0]    coef_previous,
   input  wire logic signed [dwg_pkg::COEF_W-1:0]    coef_neighbour,
   output logic signed [dwg_pkg::VAL_W-1:0]          cell_value
);
   import dwg_pkg::*;
   localparam int CELLS = COLS * ROWS;

   // Three banks rotate between now, before and next; after a step the
   // next bank becomes now and old now becomes before.
   logic signed [VAL_W-1:0] bank0 [CELLS];
   logic signed [VAL_W-1:0] bank1 [CELLS];
   logic signed [VAL_W-1:0] bank2 [CELLS];
   logic [1:0] now_sel_ff, now_sel_in;

   logic [1:0] prev_sel, next_sel;
   assign prev_sel = (now_sel_ff == 2'd0) ? 2'd2 : now_sel_ff - 2'd1;
   assign next_sel = (now_sel_ff == 2'd2) ? 2'd0 : now_sel_ff + 2'd1;

   // Window: now stream read ahead by COLS+1 so up/down/left/right are in taps.
   localparam int WIN = 2 * COLS + 1;
   logic signed [VAL_W-1:0] win_ff [WIN];
   logic signed [VAL_W-1:0] rd0_ff, rd1_ff, rd2_ff;
   logic load_d_ff;
   logic [IDX_W-1:0] cadr;
   assign cadr = cmd.addr;

   always_ff @(posedge clock) begin
      rd0_ff <= bank0[cadr];
      rd1_ff <= bank1[cadr];
      rd2_ff <= bank2[cadr];
   end

   logic signed [VAL_W-1:0] now_rd, prev_rd;
   always_comb begin
      unique case (now_sel_ff)
         2'd0: now_rd = rd0_ff;
         2'd1: now_rd = rd1_ff;
         default: now_rd = rd2_ff;
      endcase
   end

   // previous value read through a second port; it arrives in the same cycle as
   // the registered center (ctr_ff) and goes straight into its multiplier
   logic signed [VAL_W-1:0] p0_ff, p1_ff, p2_ff;
   always_ff @(posedge clock) begin
      p0_ff <= bank0[cmd.wb_addr];
      p1_ff <= bank1[cmd.wb_addr];
      p2_ff <= bank2[cmd.wb_addr];
   end
   always_comb begin
      unique case (prev_sel)
         2'd0: prev_rd = p0_ff;
         2'd1: prev_rd = p1_ff;
         default: prev_rd = p2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      load_d_ff <= cmd.load;
      if (cmd.sweep) begin
         win_ff[0] <= load_d_ff ? now_rd : '0;
         for (int k = 1; k < WIN; k++) win_ff[k] <= win_ff[k-1];
      end
   end

   // Stage 1: center at win[COLS], neighbours around it.
   logic s1_ff, s2_ff;
   logic signed [VAL_W-1:0] ctr_ff;
   logic signed [VAL_W+1:0] nsum_ff;
   logic [IDX_W-1:0] a1_ff, a2_ff;
   logic signed [VAL_W+1:0] nsum_in;
   always_comb begin
      nsum_in = '0;
      if (cmd.wb_row != 9'd0) nsum_in = nsum_in + win_ff[WIN-1];
      if (32'(cmd.wb_row) != ROWS - 1) nsum_in = nsum_in + win_ff[0];
      if (cmd.wb_col != 9'd0) nsum_in = nsum_in + win_ff[COLS+1];
      if (32'(cmd.wb_col) != COLS - 1) nsum_in = nsum_in + win_ff[COLS-1];
   end

   logic signed [53:0] m_self_ff, m_prev_ff, m_nbr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.wb;
         s2_ff <= s1_ff;
      end
      ctr_ff <= win_ff[COLS];
      nsum_ff <= nsum_in;
      a1_ff <= cmd.wb_addr;
      m_self_ff <= 54'(coef_self * ctr_ff);
      m_prev_ff <= 54'(coef_previous * prev_rd);
      m_nbr_ff <= 54'(coef_neighbour * nsum_ff);
      a2_ff <= a1_ff;
   end

   logic signed [54:0] acc;
   logic signed [38:0] rnd;
   assign acc = 55'(m_self_ff) + 55'(m_prev_ff) + 55'(m_nbr_ff) + 55'sd32768;
   assign rnd = acc[54:16];
   logic signed [VAL_W-1:0] res;
   always_comb begin
      if (rnd > 39'sh7FFFFFFF) res = 32'sh7FFFFFFF;
      else if (rnd < -39'sh80000000) res = 32'sh80000000;
      else res = rnd[VAL_W-1:0];
   end

   // Add/read path on the now bank.
   logic signed [VAL_W-1:0] sum_v;
   assign sum_v = sat32(34'(now_rd) + 34'(delta));
   logic [1:0] ws;
   logic signed [VAL_W-1:0] wd;
   logic [IDX_W-1:0] wa;
   logic we;
   always_comb begin
      we = 1'b0;
      ws = next_sel;
      wd = res;
      wa = a2_ff;
      if (cmd.clr) begin
         // clearing pass writes all three banks
         wd = '0;
         wa = cadr;
      end else if (s2_ff) we = 1'b1;
      else if (cmd.cell_wr && index_ok) begin
         we = 1'b1;
         ws = now_sel_ff;
         wd = sum_v;
         wa = cell_index;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.clr || (we && ws == 2'd0)) bank0[wa] <= wd;
      if (cmd.clr || (we && ws == 2'd1)) bank1[wa] <= wd;
      if (cmd.clr || (we && ws == 2'd2)) bank2[wa] <= wd;
   end

   always_ff @(posedge clock) begin
      if (reset) now_sel_ff <= 2'd0;
      else now_sel_ff <= now_sel_in;
      if (cmd.cell_rd) cell_value <= '0;
      else if (cmd.cell_wr) cell_value <= index_ok ? sum_v : '0;
      else if (cmd.wb_hold) cell_value <= index_ok ? now_rd : '0;
   end
   assign now_sel_in = cmd.bank_flip ? next_sel : now_sel_ff;
endmodule
`default_nettype wire

>>> hw/rtl/dwg_ctrl.sv
// Controller of the damped wave grid: clearing pass, step sweep sequencing,
// add/read sequencing and handshakes. Depends on dwg_pkg.
`default_nettype none
module dwg_ctrl #(
   parameter int COLS = dwg_pkg::DEFAULT_COLS,
   parameter int ROWS = dwg_pkg::DEFAULT_ROWS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [dwg_pkg::OP_W-1:0]     opcode,
   input  wire logic [dwg_pkg::IDX_W-1:0]    cell_index,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output logic [dwg_pkg::OP_W-1:0]          out_opcode,
   output logic                              index_ok,
   output dwg_pkg::dwg_cmd_type              cmd
);
   import dwg_pkg::*;
   localparam int CELLS = COLS * ROWS;
   localparam int LEAD = COLS + 1;
   localparam int CNT_W = $clog2(CELLS + LEAD + 4) + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_CELL = 3'd3;
   localparam logic [2:0] ST_CELL2 = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [8:0] row_ff, row_in, col_ff, col_in;

   assign index_ok = 32'(idx_ff) < CELLS;
   assign out_opcode = op_ff;
   assign out_valid = state_ff == ST_OUT;
   assign in_ready = state_ff == ST_IDLE || (state_ff == ST_OUT && out_ready);

   logic take;
   assign take = in_valid && in_ready && opcode != OP_NONE;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      op_in = op_ff;
      idx_in = idx_ff;
      row_in = row_ff;
      col_in = col_ff;
      cmd = '0;
      cmd.addr = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            cmd.addr = cnt_ff[IDX_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == CELLS - 1) state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            // cnt: read address; wb_addr trails it by LEAD+1 cells
            cmd.sweep = 1'b1;
            cmd.load = 32'(cnt_ff) < CELLS;
            cmd.addr = cmd.load ? cnt_ff[IDX_W-1:0] : '0;
            cmd.wb = 32'(cnt_ff) >= LEAD + 1 && 32'(cnt_ff) < CELLS + LEAD + 1;
            cmd.wb_addr = IDX_W'(cnt_ff - CNT_W'(LEAD + 1));
            cmd.wb_row = row_ff;
            cmd.wb_col = col_ff;
            if (cmd.wb) begin
               if (32'(col_ff) == COLS - 1) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else col_in = col_ff + 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == CELLS + LEAD + 3) begin
               cmd.bank_flip = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_CELL: begin
            state_in = ST_CELL2;
         end
         ST_CELL2: begin
            if (op_ff == OP_ADD) cmd.cell_wr = 1'b1;
            else cmd.wb_hold = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: ;
      endcase
      if (take) begin
         op_in = opcode;
         idx_in = cell_index;
         cnt_in = '0;
         row_in = '0;
         col_in = '0;
         if (opcode == OP_STEP) begin
            state_in = ST_SWEEP;
            // step result is zero; clear output register now
            cmd.cell_rd = 1'b1;
         end else state_in = ST_CELL;
         cmd.addr = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      op_ff <= op_in;
      idx_ff <= idx_in;
      row_ff <= row_in;
      col_ff <= col_in;
   end
endmodule
`default_nettype wire

>>> hw/rtl/damped_wave_grid_step.sv
// Top level of the damped wave grid: coefficient registers, controller and
// datapath. Depends on dwg_pkg, dwg_ctrl, dwg_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Damped 2-D wave grid. After reset a clearing pass over all GRID_ROWS*GRID_COLS
// cells (4096 by default) zeroes the grids; no item is taken meanwhile. A
// step item sweeps the grid one cell per cycle through a line-buffer window,
// then flips the banks once the window lead and pipeline have drained. Add
// and read items pass through ST_CELL and ST_CELL2 (read, then write or
// capture) before the result is offered. One item is worked at a time; the
// result waits in an output register. Opcode 3 is consumed with no result. The
// user must write coefficients only while idle; the block does not enforce it.
module damped_wave_grid_step #(
   parameter int GRID_COLS = dwg_pkg::DEFAULT_COLS,
   parameter int GRID_ROWS = dwg_pkg::DEFAULT_ROWS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [47:0]   req_tdata,   // opcode[1:0], cell_index[13:2], delta[45:14]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [39:0]        rsp_tdata,   // cell_value[31:0], done_opcode[33:32]
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [19:0]   csr_data
);
   import dwg_pkg::*;

   logic signed [COEF_W-1:0] self_ff, prev_ff, nbr_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff <= COEF_SELF_RST;
         prev_ff <= COEF_PREV_RST;
         nbr_ff <= COEF_NBR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SELF: self_ff <= csr_data;
            CSR_PREV: prev_ff <= csr_data;
            CSR_NBR: nbr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // item fields held for the add path while the bus moves on
   logic [IDX_W-1:0] idx_ff;
   logic signed [VAL_W-1:0] delta_ff;
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         idx_ff <= req_tdata[13:2];
         delta_ff <= req_tdata[45:14];
      end
   end

   dwg_cmd_type cmd;
   logic index_ok;
   logic [OP_W-1:0] done_op;
   logic signed [VAL_W-1:0] cell_value;

   dwg_ctrl #(.COLS(GRID_COLS), .ROWS(GRID_ROWS)) u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .opcode(req_tdata[1:0]), .cell_index(req_tdata[13:2]),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_opcode(done_op), .index_ok(index_ok), .cmd(cmd)
   );

   dwg_datapath #(.COLS(GRID_COLS), .ROWS(GRID_ROWS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .cell_index(idx_ff), .delta(delta_ff),
      .index_ok(index_ok),
      .coef_self(self_ff), .coef_previous(prev_ff), .coef_neighbour(nbr_ff),
      .cell_value(cell_value)
   );

   assign rsp_tdata = {6'd0, done_op, cell_value};

   `CHK_ALWAYS(a_no_ready_while_busy, clock, reset, !(rsp_tvalid && !rsp_tready && req_tready), "ready while result stalls")
   `CHK_NEXT(a_result_held, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `CHK_ALWAYS(a_step_zero, clock, reset, !(rsp_tvalid && done_op == OP_STEP && cell_value != '0), "step result not zero")
endmodule
`default_nettype wire
